// ===== src/lkf_pkg.sv =====
// Shared types, constants and helpers for the linear Kalman filter step core.
// Holds the scratch memory map, request/result structs and saturation helper.
// No dependencies.
`default_nettype none

package lkf_pkg;

  // Largest supported dimensions; the memory map is laid out for these
  localparam int MAX_N = 4;
  localparam int MAX_M = 2;
  localparam int DEF_NUM_STATES = 4;
  localparam int DEF_NUM_MEAS = 2;

  localparam int MEM_DEPTH = 145;
  localparam int AW = 8;
  typedef logic [AW-1:0] addr_t;

  // Scratch memory map, row-major, row stride MAX_N or MAX_M
  localparam addr_t A_X   = 8'd0;
  localparam addr_t A_P   = 8'd4;
  localparam addr_t A_F   = 8'd20;
  localparam addr_t A_H   = 8'd36;
  localparam addr_t A_R   = 8'd44;
  localparam addr_t A_Q   = 8'd48;
  localparam addr_t A_NX  = 8'd64;
  localparam addr_t A_FP  = 8'd68;
  localparam addr_t A_Y   = 8'd84;
  localparam addr_t A_PHT = 8'd88;
  localparam addr_t A_S   = 8'd96;
  localparam addr_t A_SI  = 8'd100;
  localparam addr_t A_KG  = 8'd104;
  localparam addr_t A_IKH = 8'd112;
  localparam addr_t A_NP  = 8'd128;
  localparam addr_t A_DET = 8'd144;

  localparam logic signed [31:0] FX_ONE = 32'sd65536;
  localparam logic signed [31:0] FX_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] FX_MIN = 32'sh80000000;
  localparam logic signed [35:0] ACC_MAX = 36'sd2147483647;
  localparam logic signed [35:0] ACC_MIN = -36'sd2147483648;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_PREDICT = 2'd1,
    REQ_UPDATE  = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_e;

  localparam logic [2:0] SEL_X = 3'd0;
  localparam logic [2:0] SEL_P = 3'd1;
  localparam logic [2:0] SEL_F = 3'd2;
  localparam logic [2:0] SEL_H = 3'd3;
  localparam logic [2:0] SEL_R = 3'd4;
  localparam logic [2:0] SEL_Q = 3'd5;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         matrix_select;
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic signed [31:0] load_value;
    logic signed [31:0] meas_first;
    logic signed [31:0] meas_second;
  } req_t;

  typedef struct packed {
    logic [1:0]         est_index;
    logic signed [31:0] est_value;
    logic               singular_flag;
    logic               last_flag;
  } est_t;

  // Control that travels with each product term through the MAC
  typedef struct packed {
    logic  first;     // first term of an element
    logic  last;      // last term, write the element
    logic  neg;       // subtract this term
    logic  b_one;     // second operand is 1.0
    logic  ident;     // start from 1.0 instead of 0
    logic  post_sub;  // result is z - sum
    logic  zsel;      // which z
    addr_t dest;
  } mac_tag_t;

  // Element address, stride MAX_N
  function automatic addr_t at4(input addr_t base, input logic [2:0] r, input logic [2:0] c);
    return base + {r[2:0], 2'b00} + {5'b0, c};
  endfunction

  // Element address, stride MAX_M
  function automatic addr_t at2(input addr_t base, input logic [2:0] r, input logic [2:0] c);
    return base + {4'b0, r[2:0], 1'b0} + {5'b0, c};
  endfunction

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    if (v > ACC_MAX) begin
      return FX_MAX;
    end else if (v < ACC_MIN) begin
      return FX_MIN;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/linear_kalman_filter_step_core.sv =====
// Top level of the linear Kalman filter step: sequencer, address generation,
// load port and result output. Uses lkf_pkg, lkf_mem, lkf_mac and lkf_div.
//
// Usage: requests arrive on req (valid/ready). A load request writes one entry
// of x, P, F, H, R or Q as it is accepted and gives no result. Predict and
// update requests run a sequence of dot products through one shared
// multiply-accumulate; the terms of each dot product issue back to back and
// the MAC pipeline drains between matrix phases. The inverse of S goes
// through one shared divider, one entry at a time. Both then return
// NUM_STATES results on res (valid/ready), index 0 first, the last one marked.
// When S is singular the gain and covariance phases are skipped. Each result
// is read from the store, then loaded into the result register and shown
// on res until it is taken. req_ready is high only between requests, so
// one request is in flight at a time; while the receiver holds res_ready low
// the result stays on res unchanged and the block waits. Reset returns the
// sequencer to idle and drops res_valid; the matrix store is not cleared and
// every entry must be loaded before it is used.
`default_nettype none

module linear_kalman_filter_step_core
  import lkf_pkg::*;
#(
  parameter int NUM_STATES = DEF_NUM_STATES,
  parameter int NUM_MEAS   = DEF_NUM_MEAS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      res_valid,
  input  wire logic res_ready,
  output est_t      res
);

  localparam logic [2:0] NL = 3'(NUM_STATES);
  localparam logic [2:0] ML = 3'(NUM_MEAS);
  localparam logic [1:0] DL = (NUM_MEAS == 2) ? 2'd3 : 2'd0;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_RUN      = 9'b000000010,
    S_DRAIN    = 9'b000000100,
    S_DIV_RD   = 9'b000001000,
    S_DIV_GO   = 9'b000010000,
    S_DIV_WAIT = 9'b000100000,
    S_EMIT_RD  = 9'b001000000,
    S_EMIT_LD  = 9'b010000000,
    S_EMIT_OUT = 9'b100000000
  } state_t;

  typedef enum logic [12:0] {
    PH_NX  = 13'b0000000000001,
    PH_FP  = 13'b0000000000010,
    PH_P   = 13'b0000000000100,
    PH_XC  = 13'b0000000001000,
    PH_Y   = 13'b0000000010000,
    PH_PHT = 13'b0000000100000,
    PH_S   = 13'b0000001000000,
    PH_DET = 13'b0000010000000,
    PH_KG  = 13'b0000100000000,
    PH_IKH = 13'b0001000000000,
    PH_NP  = 13'b0010000000000,
    PH_XU  = 13'b0100000000000,
    PH_PC  = 13'b1000000000000
  } phase_t;

  state_t             state;
  phase_t             phase;
  logic [1:0]         i, j, d, e;
  logic [2:0]         k, il, jl, kl, i3, j3;
  logic               k_end, j_end, i_end;
  logic               sing;
  logic signed [31:0] z0, z1, last_res;
  addr_t              gen_a, gen_b, raddr_a, raddr_b, num_addr;
  mac_tag_t           tag_gen, tag1;
  logic               v1;
  logic               req_acc;
  logic               ld_ok, mem_we;
  addr_t              ld_addr, mem_waddr;
  logic signed [31:0] mem_wdata, rdata_a, rdata_b;
  logic               mac_we, mac_busy;
  addr_t              mac_waddr;
  logic signed [31:0] mac_wdata;
  logic               div_start, div_done;
  logic signed [32:0] div_num;
  logic signed [31:0] div_quo;
  logic               num_neg;

  assign req_ready = (state == S_IDLE);
  assign req_acc   = req_valid & req_ready;
  assign i3 = {1'b0, i};
  assign j3 = {1'b0, j};

  // loop limits, operand addresses and term control per phase
  always_comb begin
    il      = NL;
    jl      = 3'd1;
    kl      = NL;
    gen_a   = A_X;
    gen_b   = A_X;
    tag_gen = '0;
    case (phase)
      PH_NX: begin
        gen_a = at4(A_F, i3, k);
        gen_b = A_X + addr_t'(k);
        tag_gen.dest = A_NX + addr_t'(i);
      end
      PH_FP: begin
        jl = NL;
        gen_a = at4(A_F, i3, k);
        gen_b = at4(A_P, k, j3);
        tag_gen.dest = at4(A_FP, i3, j3);
      end
      PH_P: begin
        jl = NL;
        kl = NL + 3'd1;
        if (k == NL) begin
          gen_a = at4(A_Q, i3, j3);
          tag_gen.b_one = 1'b1;
        end else begin
          gen_a = at4(A_FP, i3, k);
          gen_b = at4(A_F, j3, k);
        end
        tag_gen.dest = at4(A_P, i3, j3);
      end
      PH_XC: begin
        kl = 3'd1;
        gen_a = A_NX + addr_t'(i);
        tag_gen.b_one = 1'b1;
        tag_gen.dest = A_X + addr_t'(i);
      end
      PH_Y: begin
        il = ML;
        gen_a = at4(A_H, i3, k);
        gen_b = A_X + addr_t'(k);
        tag_gen.post_sub = 1'b1;
        tag_gen.zsel = i[0];
        tag_gen.dest = A_Y + addr_t'(i);
      end
      PH_PHT: begin
        jl = ML;
        gen_a = at4(A_P, i3, k);
        gen_b = at4(A_H, j3, k);
        tag_gen.dest = at2(A_PHT, i3, j3);
      end
      PH_S: begin
        il = ML;
        jl = ML;
        kl = NL + 3'd1;
        if (k == NL) begin
          gen_a = at2(A_R, i3, j3);
          tag_gen.b_one = 1'b1;
        end else begin
          gen_a = at4(A_H, i3, k);
          gen_b = at2(A_PHT, k, j3);
        end
        tag_gen.dest = at2(A_S, i3, j3);
      end
      PH_DET: begin
        il = 3'd1;
        kl = 3'd2;
        gen_a = (k == 3'd0) ? A_S : A_S + 8'd1;
        gen_b = (k == 3'd0) ? A_S + 8'd3 : A_S + 8'd2;
        tag_gen.neg = (k == 3'd1);
        tag_gen.dest = A_DET;
      end
      PH_KG: begin
        jl = ML;
        kl = ML;
        gen_a = at2(A_PHT, i3, k);
        gen_b = at2(A_SI, k, j3);
        tag_gen.dest = at2(A_KG, i3, j3);
      end
      PH_IKH: begin
        jl = NL;
        kl = ML;
        gen_a = at2(A_KG, i3, k);
        gen_b = at4(A_H, k, j3);
        tag_gen.neg = 1'b1;
        tag_gen.ident = (i == j);
        tag_gen.dest = at4(A_IKH, i3, j3);
      end
      PH_NP: begin
        jl = NL;
        gen_a = at4(A_IKH, i3, k);
        gen_b = at4(A_P, k, j3);
        tag_gen.dest = at4(A_NP, i3, j3);
      end
      PH_XU: begin
        kl = ML + 3'd1;
        if (k == ML) begin
          gen_a = A_X + addr_t'(i);
          tag_gen.b_one = 1'b1;
        end else begin
          gen_a = at2(A_KG, i3, k);
          gen_b = A_Y + addr_t'(k);
        end
        tag_gen.dest = A_X + addr_t'(i);
      end
      PH_PC: begin
        jl = NL;
        kl = 3'd1;
        gen_a = at4(A_NP, i3, j3);
        tag_gen.b_one = 1'b1;
        tag_gen.dest = at4(A_P, i3, j3);
      end
      default: begin
        il = NL;
      end
    endcase
    k_end = (k == kl - 3'd1);
    j_end = (j3 == jl - 3'd1);
    i_end = (i3 == il - 3'd1);
    tag_gen.first = (k == 3'd0);
    tag_gen.last  = k_end;
  end

  // inverse numerators: s11, -s01, -s10, s00
  always_comb begin
    case (d)
      2'd0: begin
        num_addr = A_S + 8'd3;
        num_neg  = 1'b0;
      end
      2'd1: begin
        num_addr = A_S + 8'd1;
        num_neg  = 1'b1;
      end
      2'd2: begin
        num_addr = A_S + 8'd2;
        num_neg  = 1'b1;
      end
      default: begin
        num_addr = A_S;
        num_neg  = 1'b0;
      end
    endcase
  end

  assign raddr_a = (state == S_DIV_RD) ? num_addr :
                   (state == S_EMIT_RD) ? A_X + addr_t'(e) : gen_a;
  assign raddr_b = gen_b;

  // load decode with range checks
  always_comb begin
    ld_ok   = 1'b0;
    ld_addr = A_X;
    case (req.matrix_select)
      SEL_X: begin
        ld_ok   = ({1'b0, req.row_index} < NL);
        ld_addr = A_X + addr_t'(req.row_index);
      end
      SEL_P: begin
        ld_ok   = ({1'b0, req.row_index} < NL) && ({1'b0, req.col_index} < NL);
        ld_addr = at4(A_P, {1'b0, req.row_index}, {1'b0, req.col_index});
      end
      SEL_F: begin
        ld_ok   = ({1'b0, req.row_index} < NL) && ({1'b0, req.col_index} < NL);
        ld_addr = at4(A_F, {1'b0, req.row_index}, {1'b0, req.col_index});
      end
      SEL_H: begin
        ld_ok   = ({1'b0, req.row_index} < ML) && ({1'b0, req.col_index} < NL);
        ld_addr = at4(A_H, {1'b0, req.row_index}, {1'b0, req.col_index});
      end
      SEL_R: begin
        ld_ok   = ({1'b0, req.row_index} < ML) && ({1'b0, req.col_index} < ML);
        ld_addr = at2(A_R, {1'b0, req.row_index}, {1'b0, req.col_index});
      end
      SEL_Q: begin
        ld_ok   = ({1'b0, req.row_index} < NL) && ({1'b0, req.col_index} < NL);
        ld_addr = at4(A_Q, {1'b0, req.row_index}, {1'b0, req.col_index});
      end
      default: begin
        ld_ok = 1'b0;
      end
    endcase
  end

  // single write port: MAC, divider or load
  always_comb begin
    if (mac_we) begin
      mem_we    = 1'b1;
      mem_waddr = mac_waddr;
      mem_wdata = mac_wdata;
    end else if (div_done) begin
      mem_we    = 1'b1;
      mem_waddr = A_SI + addr_t'(d);
      mem_wdata = div_quo;
    end else begin
      mem_we    = req_acc && (req.req_type == REQ_LOAD) && ld_ok;
      mem_waddr = ld_addr;
      mem_wdata = req.load_value;
    end
  end

  lkf_mem #(.DEPTH(MEM_DEPTH)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // term control aligned with registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= (state == S_RUN);
    end
  end
  always_ff @(posedge clk) begin
    tag1 <= tag_gen;
  end

  lkf_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .v_in   (v1),
    .tag_in (tag1),
    .a      (rdata_a),
    .b      (rdata_b),
    .z0     (z0),
    .z1     (z1),
    .we     (mac_we),
    .waddr  (mac_waddr),
    .wdata  (mac_wdata),
    .busy   (mac_busy)
  );

  assign div_start = (state == S_DIV_GO);
  assign div_num   = (NUM_MEAS == 1) ? 33'sd65536 :
                     (num_neg ? -{rdata_a[31], rdata_a} : {rdata_a[31], rdata_a});

  lkf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (last_res),
    .done  (div_done),
    .quo   (div_quo)
  );

  // last MAC result: S or det for the singular test
  always_ff @(posedge clk) begin
    if (mac_we) begin
      last_res <= mac_wdata;
    end
  end

  // measurement capture
  always_ff @(posedge clk) begin
    if (req_acc && (req.req_type == REQ_UPDATE)) begin
      z0 <= req.meas_first;
      z1 <= req.meas_second;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_EMIT_LD) begin
      res.est_index     <= e;
      res.est_value     <= rdata_a;
      res.singular_flag <= sing;
      res.last_flag     <= ({1'b0, e} == NL - 3'd1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_NX;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      d         <= '0;
      e         <= '0;
      sing      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          i <= '0;
          j <= '0;
          k <= '0;
          if (req_acc && (req.req_type == REQ_PREDICT)) begin
            phase <= PH_NX;
            sing  <= 1'b0;
            state <= S_RUN;
          end else if (req_acc && (req.req_type == REQ_UPDATE)) begin
            phase <= PH_Y;
            sing  <= 1'b0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (k_end) begin
            k <= '0;
            if (j_end) begin
              j <= '0;
              if (i_end) begin
                i     <= '0;
                state <= S_DRAIN;
              end else begin
                i <= i + 2'd1;
              end
            end else begin
              j <= j + 2'd1;
            end
          end else begin
            k <= k + 3'd1;
          end
        end
        S_DRAIN: begin
          if (!mac_busy) begin
            e <= '0;
            d <= '0;
            case (phase)
              PH_NX: begin
                phase <= PH_FP;
                state <= S_RUN;
              end
              PH_FP: begin
                phase <= PH_P;
                state <= S_RUN;
              end
              PH_P: begin
                phase <= PH_XC;
                state <= S_RUN;
              end
              PH_Y: begin
                phase <= PH_PHT;
                state <= S_RUN;
              end
              PH_PHT: begin
                phase <= PH_S;
                state <= S_RUN;
              end
              PH_KG: begin
                phase <= PH_IKH;
                state <= S_RUN;
              end
              PH_IKH: begin
                phase <= PH_NP;
                state <= S_RUN;
              end
              PH_NP: begin
                phase <= PH_XU;
                state <= S_RUN;
              end
              PH_XU: begin
                phase <= PH_PC;
                state <= S_RUN;
              end
              PH_S, PH_DET: begin
                if ((NUM_MEAS == 2) && (phase == PH_S)) begin
                  phase <= PH_DET;
                  state <= S_RUN;
                end else if (last_res == 32'sd0) begin
                  sing  <= 1'b1;
                  state <= S_EMIT_RD;
                end else begin
                  state <= S_DIV_RD;
                end
              end
              default: state <= S_EMIT_RD;
            endcase
          end
        end
        S_DIV_RD: state <= S_DIV_GO;
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            if (d == DL) begin
              phase <= PH_KG;
              state <= S_RUN;
            end else begin
              d     <= d + 2'd1;
              state <= S_DIV_RD;
            end
          end
        end
        S_EMIT_RD: state <= S_EMIT_LD;
        S_EMIT_LD: begin
          res_valid <= 1'b1;
          state     <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            if ({1'b0, e} == NL - 3'd1) begin
              state <= S_IDLE;
            end else begin
              e     <= e + 2'd1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // MAC and divider never compete for the write port
  a_wport: assert property (@(posedge clk) disable iff (rst) !(mac_we && div_done))
    else $error("MAC and divider write in the same cycle");
  // no request is taken while terms are still in flight
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst) req_ready |-> !mac_busy)
    else $error("request taken with MAC busy");
  // a result is only shown in the output state
  a_res_state: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (state == S_EMIT_OUT))
    else $error("result valid outside output state");
  // divider finishes only while it is awaited
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_WAIT))
    else $error("divider done while not awaited");
  // phase register stays one-hot
  a_phase: assert property (@(posedge clk) disable iff (rst) $onehot(phase))
    else $error("phase not one-hot");
`endif

endmodule

`default_nettype wire

// ===== src/lkf_mem.sv =====
// Scratch memory: one write port, two registered read ports.
// Depends on lkf_pkg for the address type.
`default_nettype none

module lkf_mem
  import lkf_pkg::*;
#(
  parameter int DEPTH = MEM_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire addr_t              waddr,
  input  wire logic signed [31:0] wdata,
  input  wire addr_t              raddr_a,
  input  wire addr_t              raddr_b,
  output logic signed [31:0]      rdata_a,
  output logic signed [31:0]      rdata_b
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== src/lkf_mac.sv =====
// Shared pipelined multiply-accumulate: multiply, scale and saturate, accumulate,
// then final saturation and write-back. Depends on lkf_pkg.
`default_nettype none

module lkf_mac
  import lkf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               v_in,
  input  wire mac_tag_t           tag_in,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  input  wire logic signed [31:0] z0,
  input  wire logic signed [31:0] z1,
  output logic                    we,
  output addr_t                   waddr,
  output logic signed [31:0]      wdata,
  output logic                    busy
);

  logic               v2, v3, v4;
  mac_tag_t           tag2, tag3, tag4;
  logic signed [31:0] bsel;
  logic signed [63:0] prod;
  logic signed [47:0] q, qt;
  logic signed [31:0] qs;
  logic signed [32:0] term;
  logic signed [35:0] acc;
  logic signed [31:0] r, zval;

  // valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v2 <= v_in;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 2: product
  assign bsel = tag_in.b_one ? FX_ONE : b;
  always_ff @(posedge clk) begin
    prod <= a * bsel;
    tag2 <= tag_in;
  end

  // stage 3: divide by 2^16 toward zero, saturate, apply sign
  assign q  = prod[63:16];
  assign qt = q + {47'b0, prod[63] & (|prod[15:0])};
  always_comb begin
    if (qt > 48'sd2147483647) begin
      qs = FX_MAX;
    end else if (qt < -48'sd2147483648) begin
      qs = FX_MIN;
    end else begin
      qs = qt[31:0];
    end
  end
  always_ff @(posedge clk) begin
    term <= tag2.neg ? -{qs[31], qs} : {qs[31], qs};
    tag3 <= tag2;
  end

  // stage 4: accumulate
  always_ff @(posedge clk) begin
    if (tag3.first) begin
      acc <= (tag3.ident ? 36'sd65536 : 36'sd0) + 36'(term);
    end else begin
      acc <= acc + 36'(term);
    end
    tag4 <= tag3;
  end

  // write-back
  assign r     = sat36(acc);
  assign zval  = tag4.zsel ? z1 : z0;
  assign wdata = tag4.post_sub ? sat36(36'(zval) - 36'(r)) : r;
  assign waddr = tag4.dest;
  assign we    = v4 & tag4.last;
  assign busy  = v_in | v2 | v3 | v4;

endmodule

`default_nettype wire

// ===== src/lkf_div.sv =====
// Radix-2 restoring divider for (num * 2^16) / den, truncated and saturated.
// 48 steps per quotient. Depends on lkf_pkg.
`default_nettype none

module lkf_div
  import lkf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [32:0] num,
  input  wire logic signed [31:0] den,
  output logic                    done,
  output logic signed [31:0]      quo
);

  logic        busy;
  logic [5:0]  cnt;
  logic [47:0] dvd;
  logic [31:0] rem, dmag;
  logic        qneg;
  logic [32:0] nmag, dm33, rem_sh;
  logic        ge;

  assign nmag   = num[32] ? -num : num;
  assign dm33   = den[31] ? -{den[31], den} : {den[31], den};
  assign rem_sh = {rem, dvd[47]};
  assign ge     = rem_sh >= {1'b0, dmag};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd47;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= {nmag[31:0], 16'b0};
      rem  <= '0;
      dmag <= dm33[31:0];
      qneg <= num[32] ^ den[31];
    end else if (busy) begin
      rem <= ge ? 32'(rem_sh - {1'b0, dmag}) : rem_sh[31:0];
      dvd <= {dvd[46:0], ge};
    end
  end

  // sign and saturation
  always_comb begin
    if (qneg) begin
      quo = (dvd > 48'd2147483648) ? FX_MIN : 32'(32'd0 - dvd[31:0]);
    end else begin
      quo = (dvd > 48'd2147483647) ? FX_MAX : dvd[31:0];
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for linear_kalman_filter_step_core (4 states, 2 measurements).
// Depends on lkf_pkg for the request and result structs; it carries its own Q16.16 filter
// predictor.
`default_nettype none

module tb;
  import lkf_pkg::*;

  localparam int NS = DEF_NUM_STATES;
  localparam int NM = DEF_NUM_MEAS;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  est_t res;

  // Filter state as the predictor sees it
  int kx[NS];
  int kp[NS][NS];
  int kf[NS][NS];
  int kh[NM][NS];
  int kr[NM][NM];
  int kq[NS][NS];

  est_t est_q[$];
  int   mismatches = 0;
  int   cyc = 0;
  bit   quiet = 1'b0;
  int   hold_req = 0;

  linear_kalman_filter_step_core u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fixed point helpers
  function automatic int sat(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint qmul(input int a, input int b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return longint'(sat(prod / 64'sd65536));
  endfunction

  function automatic int qdiv(input longint n, input int d);
    return sat((n * 64'sd65536) / longint'(d));
  endfunction

  // Apply one load request to the predictor
  task automatic model_load(input req_t r);
    int ri;
    int ci;
    ri = r.row_index;
    ci = r.col_index;
    case (r.matrix_select)
      SEL_X: kx[ri] = r.load_value;
      SEL_P: kp[ri][ci] = r.load_value;
      SEL_F: kf[ri][ci] = r.load_value;
      SEL_H: if (ri < NM) kh[ri][ci] = r.load_value;
      SEL_R: if (ri < NM && ci < NM) kr[ri][ci] = r.load_value;
      SEL_Q: kq[ri][ci] = r.load_value;
      default: ;
    endcase
  endtask

  // x = F x, P = F P F' + Q
  task automatic model_predict();
    int nx[NS];
    int fp[NS][NS];
    longint acc;
    for (int i = 0; i < NS; i++) begin
      acc = 0;
      for (int k = 0; k < NS; k++) acc += qmul(kf[i][k], kx[k]);
      nx[i] = sat(acc);
    end
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NS; j++) begin
        acc = 0;
        for (int k = 0; k < NS; k++) acc += qmul(kf[i][k], kp[k][j]);
        fp[i][j] = sat(acc);
      end
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NS; j++) begin
        acc = kq[i][j];
        for (int k = 0; k < NS; k++) acc += qmul(fp[i][k], kf[j][k]);
        kp[i][j] = sat(acc);
      end
    for (int i = 0; i < NS; i++) kx[i] = nx[i];
  endtask

  // Measurement update; returns 1 when S is singular and nothing changes
  function automatic bit model_update(input int z0, input int z1);
    int z[NM];
    int y[NM];
    int pht[NS][NM];
    int s[NM][NM];
    int si[NM][NM];
    int kg[NS][NM];
    int ikh[NS][NS];
    int np[NS][NS];
    int det;
    longint acc;
    z[0] = z0;
    z[1] = z1;
    for (int i = 0; i < NM; i++) begin
      acc = 0;
      for (int k = 0; k < NS; k++) acc += qmul(kh[i][k], kx[k]);
      y[i] = sat(longint'(z[i]) - longint'(sat(acc)));
    end
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NM; j++) begin
        acc = 0;
        for (int k = 0; k < NS; k++) acc += qmul(kp[i][k], kh[j][k]);
        pht[i][j] = sat(acc);
      end
    for (int i = 0; i < NM; i++)
      for (int j = 0; j < NM; j++) begin
        acc = kr[i][j];
        for (int k = 0; k < NS; k++) acc += qmul(kh[i][k], pht[k][j]);
        s[i][j] = sat(acc);
      end
    det = sat(qmul(s[0][0], s[1][1]) - qmul(s[0][1], s[1][0]));
    if (det == 0) return 1'b1;
    si[0][0] = qdiv(longint'(s[1][1]), det);
    si[0][1] = qdiv(-longint'(s[0][1]), det);
    si[1][0] = qdiv(-longint'(s[1][0]), det);
    si[1][1] = qdiv(longint'(s[0][0]), det);
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NM; j++) begin
        acc = 0;
        for (int k = 0; k < NM; k++) acc += qmul(pht[i][k], si[k][j]);
        kg[i][j] = sat(acc);
      end
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NS; j++) begin
        acc = 0;
        for (int k = 0; k < NM; k++) acc += qmul(kg[i][k], kh[k][j]);
        ikh[i][j] = sat((i == j ? 64'sd65536 : 64'sd0) - acc);
      end
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NS; j++) begin
        acc = 0;
        for (int k = 0; k < NS; k++) acc += qmul(ikh[i][k], kp[k][j]);
        np[i][j] = sat(acc);
      end
    for (int i = 0; i < NS; i++) begin
      acc = kx[i];
      for (int k = 0; k < NM; k++) acc += qmul(kg[i][k], y[k]);
      kx[i] = sat(acc);
    end
    kp = np;
    return 1'b0;
  endfunction

  // Work out what one accepted request should return
  task automatic predict_estimates(input req_t r);
    est_t e;
    bit sing;
    sing = 1'b0;
    case (r.req_type)
      REQ_LOAD: model_load(r);
      REQ_PREDICT: model_predict();
      REQ_UPDATE: sing = model_update(r.meas_first, r.meas_second);
      default: ;
    endcase
    if (r.req_type == REQ_PREDICT || r.req_type == REQ_UPDATE) begin
      for (int i = 0; i < NS; i++) begin
        e.est_index = i[1:0];
        e.est_value = kx[i];
        e.singular_flag = sing;
        e.last_flag = (i == NS - 1);
        est_q.push_back(e);
      end
    end
  endtask

  // Send one request; called at a falling edge, returns at a falling edge
  task automatic send_req(input req_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_estimates(r);
    @(negedge clk);
  endtask

  task automatic idle_sender();
    req_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    idle_sender();
    while (est_q.size() != 0) @(negedge clk);
  endtask

  // Random Q16.16 value, mostly modest so the filter stays out of saturation
  function automatic int rand_q();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return int'($urandom_range(0, 131072)) - 65536;
    if (sel < 8) return int'($urandom_range(0, 2097152)) - 1048576;
    if (sel < 9) return int'($urandom());
    return 0;
  endfunction

  function automatic req_t mk_load(input logic [2:0] sel, input int ri, input int ci,
                                   input int v);
    req_t r;
    r = '0;
    r.req_type = REQ_LOAD;
    r.matrix_select = sel;
    r.row_index = ri[1:0];
    r.col_index = ci[1:0];
    r.load_value = v;
    r.meas_first = $urandom();
    r.meas_second = $urandom();
    return r;
  endfunction

  function automatic req_t mk_step(input req_type_e t, input int z0, input int z1);
    req_t r;
    r.req_type = t;
    r.matrix_select = 3'($urandom_range(0, 7));
    r.row_index = 2'($urandom_range(0, 3));
    r.col_index = 2'($urandom_range(0, 3));
    r.load_value = $urandom();
    r.meas_first = z0;
    r.meas_second = z1;
    return r;
  endfunction

  // Write every entry of one target
  task automatic load_matrix(input logic [2:0] sel, input int rows, input int cols);
    for (int i = 0; i < rows; i++)
      for (int j = 0; j < cols; j++) begin
        if (sel == SEL_P || sel == SEL_Q || sel == SEL_R)
          send_req(mk_load(sel, i, j, i == j ? 32'sd65536 + ($urandom_range(0, 65535))
                                              : int'($urandom_range(0, 16384)) - 8192));
        else
          send_req(mk_load(sel, i, j, rand_q()));
      end
  endtask

  task automatic load_all();
    load_matrix(SEL_X, NS, 1);
    load_matrix(SEL_P, NS, NS);
    load_matrix(SEL_F, NS, NS);
    load_matrix(SEL_H, NM, NS);
    load_matrix(SEL_R, NM, NM);
    load_matrix(SEL_Q, NS, NS);
  endtask

  // Out of range loads, unused request type, extremes and a singular S
  task automatic test_directed();
    send_req(mk_load(SEL_H, 2, 1, 32'sh7FFFFFFF));
    send_req(mk_load(SEL_R, 3, 0, 32'sh7FFFFFFF));
    send_req(mk_load(SEL_R, 0, 2, 32'sh80000000));
    send_req(mk_load(3'd6, 0, 0, 32'sh7FFFFFFF));
    send_req(mk_load(3'd7, 3, 3, 32'sh80000000));
    send_req(mk_step(REQ_NONE, 0, 0));
    send_req(mk_step(REQ_PREDICT, 0, 0));
    send_req(mk_step(REQ_UPDATE, 32'sh7FFFFFFF, 32'sh80000000));
    send_req(mk_load(SEL_X, 0, 3, 32'sh7FFFFFFF));
    send_req(mk_load(SEL_X, 3, 0, 32'sh80000000));
    send_req(mk_load(SEL_F, 0, 0, 32'sh7FFFFFFF));
    send_req(mk_step(REQ_PREDICT, 0, 0));
    send_req(mk_step(REQ_UPDATE, 32'sh80000000, 32'sh7FFFFFFF));
    // zero H and R make S singular
    for (int i = 0; i < NM; i++)
      for (int j = 0; j < NS; j++) send_req(mk_load(SEL_H, i, j, 0));
    for (int i = 0; i < NM; i++)
      for (int j = 0; j < NM; j++) send_req(mk_load(SEL_R, i, j, 0));
    send_req(mk_step(REQ_UPDATE, 32'sd65536, -32'sd65536));
    // restore a usable observation model
    load_matrix(SEL_H, NM, NS);
    load_matrix(SEL_R, NM, NM);
  endtask

  // Random mix, mostly steps, plus loads of random target and index (some out of range)
  task automatic test_random(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3)
        send_req(mk_step(REQ_PREDICT, rand_q(), rand_q()));
      else if (pick < 6)
        send_req(mk_step(REQ_UPDATE, rand_q(), rand_q()));
      else if (pick < 7)
        send_req(mk_step(REQ_NONE, rand_q(), rand_q()));
      else
        send_req(mk_load(3'($urandom_range(0, 7)), $urandom_range(0, 3),
                         $urandom_range(0, 3), rand_q()));
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    hold_req = 3000;
    for (int n = 0; n < 4; n++) send_req(mk_step(REQ_PREDICT, 0, 0));
    send_req(mk_step(REQ_UPDATE, rand_q(), rand_q()));
  endtask

  // Sender pauses until all estimates are back
  task automatic test_pause();
    wait_drained();
    test_random(20);
  endtask

  // Result ready, in bursts of stall
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        res_ready <= 1'b0;
        repeat (hold_req) @(negedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      res_ready <= 1'b1;
    end
  end

  // Compare each accepted estimate with the oldest one predicted
  always @(posedge clk) begin
    est_t want;
    if (!rst && res_valid && res_ready) begin
      if (est_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected estimate %p", res);
      end else begin
        want = est_q.pop_front();
        if (res.est_index !== want.est_index || res.est_value !== want.est_value ||
            res.singular_flag !== want.singular_flag || res.last_flag !== want.last_flag) begin
          mismatches++;
          if (mismatches <= 10) $display("estimate mismatch: want %p got %p", want, res);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    load_all();
    test_directed();
    test_random(40);
    test_backpressure();
    test_pause();
    test_random(20);
    quiet = 1'b1;
    test_random(15);
    wait_drained();
    repeat (600) @(negedge clk);
    if (mismatches == 0 && est_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
